@@ src/msgpack_stream_tokenizer_unit_defines.svh @@
// Assertion macros shared by the tokenizer checker.
`ifndef MSGPACK_STREAM_TOKENIZER_UNIT_DEFINES_SVH
`define MSGPACK_STREAM_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication check.
`define MSTU_ASSERT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication check.
`define MSTU_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ src/mstu_pkg.sv @@
// Types, codes and the type byte classifier of the MessagePack tokenizer.
`default_nettype none
package mstu_pkg;

    localparam logic [3:0] K_NIL   = 4'd0;
    localparam logic [3:0] K_BOOL  = 4'd1;
    localparam logic [3:0] K_UINT  = 4'd2;
    localparam logic [3:0] K_SINT  = 4'd3;
    localparam logic [3:0] K_FLOAT = 4'd4;
    localparam logic [3:0] K_CHUNK = 4'd5;
    localparam logic [3:0] K_BIN   = 4'd6;
    localparam logic [3:0] K_STR   = 4'd7;
    localparam logic [3:0] K_EXT   = 4'd8;
    localparam logic [3:0] K_ARRAY = 4'd9;
    localparam logic [3:0] K_MAP   = 4'd10;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_BAD  = 2'd1;
    localparam logic [1:0] FAULT_OVF  = 2'd2;

    typedef enum logic [2:0] {
        FR_TYPE,
        FR_VALUE,
        FR_BYTES,
        FR_EXTTYPE,
        FR_COLL
    } fr_code_t;

    typedef enum logic [2:0] {
        ACT_SCALAR,
        ACT_COLL,
        ACT_BYTES,
        ACT_VALUE,
        ACT_EXTTYPE,
        ACT_BAD
    } act_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SET,
        OP_PUSH,
        OP_POP
    } op_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FETCH,
        ST_NORM
    } bst_t;

    typedef struct packed {
        act_t       act;
        logic [3:0] kind;
        logic [5:0] len;
    } dec_t;

    typedef struct packed {
        logic [7:0] data;
        dec_t       dec;
    } item_t;

    typedef struct packed {
        fr_code_t    code;
        logic [3:0]  kind;
        logic [32:0] count;
    } frame_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [32:0] length;
        logic [7:0]  ext;
        logic [1:0]  fault;
    } token_t;

    function automatic dec_t classify(input logic [7:0] b);
        dec_t d;
        d.act  = ACT_SCALAR;
        d.kind = K_UINT;
        d.len  = 6'd1;
        priority if (b < 8'h80) begin
            d.kind = K_UINT;
        end
        else if (b < 8'h90) begin
            d.act  = ACT_COLL;
            d.kind = K_MAP;
            d.len  = {1'b0, b[3:0], 1'b0};
        end
        else if (b < 8'ha0) begin
            d.act  = ACT_COLL;
            d.kind = K_ARRAY;
            d.len  = {2'b00, b[3:0]};
        end
        else if (b < 8'hc0) begin
            d.act  = ACT_BYTES;
            d.kind = K_STR;
            d.len  = {1'b0, b[4:0]};
        end
        else if (b >= 8'he0) begin
            d.kind = K_SINT;
        end
        else begin
            unique case (b)
                8'hc0: d.kind = K_NIL;
                8'hc2, 8'hc3: d.kind = K_BOOL;
                8'hc4: begin d.act = ACT_VALUE; d.kind = K_BIN;   d.len = 6'd1; end
                8'hc5: begin d.act = ACT_VALUE; d.kind = K_BIN;   d.len = 6'd2; end
                8'hc6: begin d.act = ACT_VALUE; d.kind = K_BIN;   d.len = 6'd4; end
                8'hc7: begin d.act = ACT_VALUE; d.kind = K_EXT;   d.len = 6'd1; end
                8'hc8: begin d.act = ACT_VALUE; d.kind = K_EXT;   d.len = 6'd2; end
                8'hc9: begin d.act = ACT_VALUE; d.kind = K_EXT;   d.len = 6'd4; end
                8'hca: begin d.act = ACT_VALUE; d.kind = K_FLOAT; d.len = 6'd4; end
                8'hcb: begin d.act = ACT_VALUE; d.kind = K_FLOAT; d.len = 6'd8; end
                8'hcc: begin d.act = ACT_VALUE; d.kind = K_UINT;  d.len = 6'd1; end
                8'hcd: begin d.act = ACT_VALUE; d.kind = K_UINT;  d.len = 6'd2; end
                8'hce: begin d.act = ACT_VALUE; d.kind = K_UINT;  d.len = 6'd4; end
                8'hcf: begin d.act = ACT_VALUE; d.kind = K_UINT;  d.len = 6'd8; end
                8'hd0: begin d.act = ACT_VALUE; d.kind = K_SINT;  d.len = 6'd1; end
                8'hd1: begin d.act = ACT_VALUE; d.kind = K_SINT;  d.len = 6'd2; end
                8'hd2: begin d.act = ACT_VALUE; d.kind = K_SINT;  d.len = 6'd4; end
                8'hd3: begin d.act = ACT_VALUE; d.kind = K_SINT;  d.len = 6'd8; end
                8'hd4: begin d.act = ACT_EXTTYPE; d.kind = K_EXT; d.len = 6'd1; end
                8'hd5: begin d.act = ACT_EXTTYPE; d.kind = K_EXT; d.len = 6'd2; end
                8'hd6: begin d.act = ACT_EXTTYPE; d.kind = K_EXT; d.len = 6'd4; end
                8'hd7: begin d.act = ACT_EXTTYPE; d.kind = K_EXT; d.len = 6'd8; end
                8'hd8: begin d.act = ACT_EXTTYPE; d.kind = K_EXT; d.len = 6'd16; end
                8'hd9: begin d.act = ACT_VALUE; d.kind = K_STR;   d.len = 6'd1; end
                8'hda: begin d.act = ACT_VALUE; d.kind = K_STR;   d.len = 6'd2; end
                8'hdb: begin d.act = ACT_VALUE; d.kind = K_STR;   d.len = 6'd4; end
                8'hdc: begin d.act = ACT_VALUE; d.kind = K_ARRAY; d.len = 6'd2; end
                8'hdd: begin d.act = ACT_VALUE; d.kind = K_ARRAY; d.len = 6'd4; end
                8'hde: begin d.act = ACT_VALUE; d.kind = K_MAP;   d.len = 6'd2; end
                8'hdf: begin d.act = ACT_VALUE; d.kind = K_MAP;   d.len = 6'd4; end
                default: d.act = ACT_BAD;
            endcase
        end
        return d;
    endfunction

endpackage
`default_nettype wire

@@ src/mstu_front.sv @@
// Front end: accepts stream bytes, classifies them and queues them for the back end.
`default_nettype none
module mstu_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,
    output logic                q_valid,
    output mstu_pkg::item_t     q_item,
    input  wire logic           q_pop
);

    mstu_pkg::item_t ent_reg [2];
    logic            wp_reg;
    logic            wp_next;
    logic            rp_reg;
    logic            rp_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic            push;
    logic            pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rp_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg].data <= s_tdata;
            ent_reg[wp_reg].dec  <= mstu_pkg::classify(s_tdata);
        end
    end

endmodule
`default_nettype wire

@@ src/mstu_back.sv @@
// Back end: nesting stack, payload gathering, float widening and the result register.
`default_nettype none
module mstu_back
#(
    parameter int STACK_DEPTH = 32
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire mstu_pkg::item_t q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output mstu_pkg::token_t    m_tok
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    mstu_pkg::frame_t stack_mem [STACK_DEPTH];
    mstu_pkg::frame_t rdata_reg;

    mstu_pkg::bst_t   state_reg;
    mstu_pkg::bst_t   state_next;
    mstu_pkg::frame_t top_reg;
    mstu_pkg::frame_t top_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic [63:0]      accum_reg;
    logic [63:0]      accum_next;
    logic [3:0]       pw_reg;
    logic [3:0]       pw_next;
    logic [1:0]       sticky_reg;
    logic [1:0]       sticky_next;
    logic [22:0]      nm_reg;
    logic [22:0]      nm_next;
    logic [4:0]       np_reg;
    logic [4:0]       np_next;
    logic             ns_reg;
    logic             ns_next;
    logic             out_valid_reg;
    mstu_pkg::token_t out_tok_reg;

    mstu_pkg::op_t    op;
    mstu_pkg::frame_t nf;
    mstu_pkg::frame_t wr_frame;
    mstu_pkg::token_t tok;
    logic             emit;
    logic             pop_go;
    logic             norm_go;
    logic             out_free;
    logic             mem_we;
    logic             mem_re;
    logic [LVL_W-1:0] lvl_m1;
    logic [LVL_W-1:0] lvl_m2;
    logic [7:0]       b;
    logic [63:0]      v;
    logic [3:0]       w;
    logic [31:0]      f32;
    logic [32:0]      cnt_dec;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tok    = out_tok_reg;
    assign lvl_m1   = level_reg - LVL_W'(1);
    assign lvl_m2   = level_reg - LVL_W'(2);
    assign b        = q_item.data;
    assign w        = top_reg.count[3:0];
    assign cnt_dec  = top_reg.count - 33'd1;

    always_comb
    begin
        v   = {accum_reg[55:0], b};
        f32 = v[31:0];
    end

    always_comb
    begin
        op          = mstu_pkg::OP_NONE;
        nf          = '0;
        wr_frame    = top_reg;
        tok         = '0;
        emit        = 1'b0;
        q_pop       = 1'b0;
        norm_go     = 1'b0;
        accum_next  = accum_reg;
        pw_next     = pw_reg;
        sticky_next = sticky_reg;
        nm_next     = nm_reg;
        np_next     = np_reg;
        ns_next     = ns_reg;
        unique case (state_reg)
            mstu_pkg::ST_FETCH:
            begin
                op = mstu_pkg::OP_NONE;
            end
            mstu_pkg::ST_NORM:
            begin
                if (nm_reg[22] || (np_reg == 5'd0))
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        tok.kind   = mstu_pkg::K_FLOAT;
                        tok.value  = {ns_reg, 11'({6'd0, np_reg}) + 11'd874,
                                      nm_reg[21:0], 30'd0};
                        tok.length = 33'd4;
                        op         = mstu_pkg::OP_POP;
                    end
                end
                else
                begin
                    nm_next = {nm_reg[21:0], 1'b0};
                    np_next = np_reg - 5'd1;
                end
            end
            default:
            begin
                if (sticky_reg != mstu_pkg::FAULT_NONE)
                begin
                    if (q_valid && out_free)
                    begin
                        q_pop     = 1'b1;
                        emit      = 1'b1;
                        tok.fault = sticky_reg;
                    end
                end
                else if (top_reg.code == mstu_pkg::FR_COLL)
                begin
                    if (top_reg.count != 33'd0)
                    begin
                        if (level_reg >= LVL_W'(STACK_DEPTH))
                        begin
                            if (q_valid && out_free)
                            begin
                                q_pop       = 1'b1;
                                emit        = 1'b1;
                                sticky_next = mstu_pkg::FAULT_OVF;
                                tok.fault   = mstu_pkg::FAULT_OVF;
                            end
                        end
                        else
                        begin
                            wr_frame.count = cnt_dec;
                            nf.code        = mstu_pkg::FR_TYPE;
                            op             = mstu_pkg::OP_PUSH;
                        end
                    end
                    else
                    begin
                        op = mstu_pkg::OP_POP;
                    end
                end
                else if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    unique case (top_reg.code)
                        mstu_pkg::FR_VALUE:
                        begin
                            accum_next = v;
                            pw_next    = pw_reg - 4'd1;
                            if (pw_next == 4'd0)
                            begin
                                op = mstu_pkg::OP_POP;
                                tok.kind   = top_reg.kind;
                                tok.value  = v;
                                tok.length = {29'd0, w};
                                emit       = 1'b1;
                                unique case (top_reg.kind)
                                    mstu_pkg::K_SINT:
                                    begin
                                        unique case (w)
                                            4'd1: tok.value = {{56{v[7]}}, v[7:0]};
                                            4'd2: tok.value = {{48{v[15]}}, v[15:0]};
                                            4'd4: tok.value = {{32{v[31]}}, v[31:0]};
                                            default: tok.value = v;
                                        endcase
                                    end
                                    mstu_pkg::K_FLOAT:
                                    begin
                                        if (w == 4'd4)
                                        begin
                                            if (f32[30:23] == 8'hff)
                                                tok.value = {f32[31], 11'h7ff,
                                                             f32[22:0], 29'd0};
                                            else if (f32[30:23] != 8'h00)
                                                tok.value = {f32[31],
                                                    11'({3'd0, f32[30:23]}) + 11'd896,
                                                    f32[22:0], 29'd0};
                                            else if (f32[22:0] == 23'd0)
                                                tok.value = {f32[31], 63'd0};
                                            else
                                            begin
                                                emit    = 1'b0;
                                                op      = mstu_pkg::OP_NONE;
                                                norm_go = 1'b1;
                                                nm_next = f32[22:0];
                                                np_next = 5'd22;
                                                ns_next = f32[31];
                                            end
                                        end
                                    end
                                    mstu_pkg::K_BIN, mstu_pkg::K_STR:
                                    begin
                                        tok.value  = '0;
                                        tok.length = {1'b0, v[31:0]};
                                        if (v[31:0] != 32'd0)
                                        begin
                                            op       = mstu_pkg::OP_SET;
                                            nf.code  = mstu_pkg::FR_BYTES;
                                            nf.kind  = top_reg.kind;
                                            nf.count = {1'b0, v[31:0]};
                                        end
                                    end
                                    mstu_pkg::K_EXT:
                                    begin
                                        emit     = 1'b0;
                                        op       = mstu_pkg::OP_SET;
                                        nf.code  = mstu_pkg::FR_EXTTYPE;
                                        nf.kind  = mstu_pkg::K_EXT;
                                        nf.count = {1'b0, v[31:0]};
                                    end
                                    mstu_pkg::K_ARRAY, mstu_pkg::K_MAP:
                                    begin
                                        tok.value = '0;
                                        if (top_reg.kind == mstu_pkg::K_MAP)
                                            tok.length = {v[31:0], 1'b0};
                                        else
                                            tok.length = {1'b0, v[31:0]};
                                        op       = mstu_pkg::OP_SET;
                                        nf.code  = mstu_pkg::FR_COLL;
                                        nf.kind  = top_reg.kind;
                                        nf.count = tok.length;
                                    end
                                    default: tok.kind = mstu_pkg::K_UINT;
                                endcase
                            end
                        end
                        mstu_pkg::FR_EXTTYPE:
                        begin
                            emit       = 1'b1;
                            tok.kind   = mstu_pkg::K_EXT;
                            tok.length = top_reg.count;
                            tok.ext    = b;
                            if (top_reg.count != 33'd0)
                            begin
                                op       = mstu_pkg::OP_SET;
                                nf.code  = mstu_pkg::FR_BYTES;
                                nf.kind  = mstu_pkg::K_EXT;
                                nf.count = top_reg.count;
                            end
                            else
                                op = mstu_pkg::OP_POP;
                        end
                        mstu_pkg::FR_BYTES:
                        begin
                            emit       = 1'b1;
                            tok.kind   = mstu_pkg::K_CHUNK;
                            tok.value  = {56'd0, b};
                            tok.length = 33'd1;
                            if (cnt_dec == 33'd0)
                                op = mstu_pkg::OP_POP;
                            else
                            begin
                                op       = mstu_pkg::OP_SET;
                                nf       = top_reg;
                                nf.count = cnt_dec;
                            end
                        end
                        default:
                        begin
                            nf.kind  = q_item.dec.kind;
                            nf.count = {27'd0, q_item.dec.len};
                            unique case (q_item.dec.act)
                                mstu_pkg::ACT_SCALAR:
                                begin
                                    emit       = 1'b1;
                                    tok.kind   = q_item.dec.kind;
                                    tok.length = 33'd1;
                                    if (q_item.dec.kind == mstu_pkg::K_SINT)
                                        tok.value = {56'hffffffffffffff, b};
                                    else if (q_item.dec.kind == mstu_pkg::K_BOOL)
                                        tok.value = {63'd0, b[0]};
                                    else if (q_item.dec.kind == mstu_pkg::K_UINT)
                                        tok.value = {56'd0, b};
                                    if (level_reg > LVL_W'(1))
                                        op = mstu_pkg::OP_POP;
                                end
                                mstu_pkg::ACT_BAD:
                                begin
                                    emit        = 1'b1;
                                    sticky_next = mstu_pkg::FAULT_BAD;
                                    tok.fault   = mstu_pkg::FAULT_BAD;
                                end
                                default:
                                begin
                                    nf.code = mstu_pkg::FR_TYPE;
                                    unique case (q_item.dec.act)
                                        mstu_pkg::ACT_COLL:    nf.code = mstu_pkg::FR_COLL;
                                        mstu_pkg::ACT_BYTES:   nf.code = mstu_pkg::FR_BYTES;
                                        mstu_pkg::ACT_VALUE:   nf.code = mstu_pkg::FR_VALUE;
                                        default:               nf.code = mstu_pkg::FR_EXTTYPE;
                                    endcase
                                    if ((q_item.dec.act == mstu_pkg::ACT_COLL) ||
                                        (q_item.dec.act == mstu_pkg::ACT_BYTES))
                                    begin
                                        emit       = 1'b1;
                                        tok.kind   = q_item.dec.kind;
                                        tok.length = {27'd0, q_item.dec.len};
                                    end
                                    if (q_item.dec.act == mstu_pkg::ACT_VALUE)
                                    begin
                                        accum_next = '0;
                                        pw_next    = q_item.dec.len[3:0];
                                    end
                                    if ((q_item.dec.act == mstu_pkg::ACT_BYTES) &&
                                        (q_item.dec.len == 6'd0))
                                    begin
                                        if (level_reg > LVL_W'(1))
                                            op = mstu_pkg::OP_POP;
                                    end
                                    else if (level_reg > LVL_W'(1))
                                        op = mstu_pkg::OP_SET;
                                    else
                                        op = mstu_pkg::OP_PUSH;
                                end
                            endcase
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        top_next   = top_reg;
        level_next = level_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        pop_go     = 1'b0;
        unique case (op)
            mstu_pkg::OP_SET:
                top_next = nf;
            mstu_pkg::OP_PUSH:
            begin
                mem_we     = 1'b1;
                top_next   = nf;
                level_next = level_reg + LVL_W'(1);
            end
            mstu_pkg::OP_POP:
            begin
                mem_re     = 1'b1;
                pop_go     = 1'b1;
                level_next = lvl_m1;
            end
            default:
                top_next = top_reg;
        endcase
        if (state_reg == mstu_pkg::ST_FETCH)
            top_next = rdata_reg;
    end

    always_comb
    begin
        unique case (state_reg)
            mstu_pkg::ST_RUN:
            begin
                if (pop_go)
                    state_next = mstu_pkg::ST_FETCH;
                else if (norm_go)
                    state_next = mstu_pkg::ST_NORM;
                else
                    state_next = mstu_pkg::ST_RUN;
            end
            mstu_pkg::ST_NORM:
                state_next = pop_go ? mstu_pkg::ST_FETCH : mstu_pkg::ST_NORM;
            default:
                state_next = mstu_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mstu_pkg::ST_RUN;
            top_reg       <= '0;
            level_reg     <= LVL_W'(1);
            pw_reg        <= 4'd0;
            sticky_reg    <= mstu_pkg::FAULT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            top_reg    <= top_next;
            level_reg  <= level_next;
            pw_reg     <= pw_next;
            sticky_reg <= sticky_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        accum_reg <= accum_next;
        nm_reg    <= nm_next;
        np_reg    <= np_next;
        ns_reg    <= ns_next;
        if (emit)
            out_tok_reg <= tok;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[lvl_m1[IDX_W-1:0]] <= wr_frame;
        if (mem_re)
            rdata_reg <= stack_mem[lvl_m2[IDX_W-1:0]];
    end

endmodule
`default_nettype wire

@@ src/msgpack_stream_tokenizer_unit.sv @@
// Top level of the MessagePack stream tokenizer.
// Takes one encoded byte per transfer and returns at most one token per byte, in order.
// A byte that needs no stack pop is consumed in the run state alone; a byte that closes a
// value, a body or a scalar inside a container is followed by the fetch state, the read of
// the stack memory below the cached top frame. Each element opened inside an array or
// map costs a push step before the next byte is used, and each finished container
// closed costs a pop step and a fetch. A subnormal float32 adds up to 22 one-bit
// normalization steps and the step that emits the token. A two-entry queue separates
// the byte classifier from the stack engine; the result register takes a new token in
// the cycle the previous one is read out, and a token that is not taken holds the next
// byte in the queue. The stack memory has no clearing pass: entries are only read after
// they were pushed.
`default_nettype none
module msgpack_stream_tokenizer_unit
#(
    parameter int STACK_DEPTH = 32
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // data_byte
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [111:0]        m_tdata,   // token_value, token_length, ext_kind, fault
    output logic [3:0]          m_tuser    // token_kind
);

    logic             q_valid;
    logic             q_pop;
    mstu_pkg::item_t  q_item;
    mstu_pkg::token_t tok;

    mstu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    mstu_back #(.STACK_DEPTH(STACK_DEPTH)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tok    (tok)
    );

    assign m_tdata = {5'd0, tok.fault, tok.ext, tok.length, tok.value};
    assign m_tuser = tok.kind;

endmodule
`default_nettype wire

@@ src/mstu_checker.sv @@
// Port-level checks of the tokenizer, bound to the top level.
`default_nettype none
`include "msgpack_stream_tokenizer_unit_defines.svh"
module mstu_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [111:0] m_tdata,
    input wire logic [3:0]   m_tuser
);

    `MSTU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `MSTU_ASSERT(a_fault_nil, clk, rst_n, m_tvalid && (m_tdata[106:105] != 2'd0), (m_tuser == 4'd0) && (m_tdata[104:0] == 105'd0), "fault result carries a token")
    `MSTU_ASSERT(a_codes, clk, rst_n, m_tvalid, (m_tuser <= 4'd10) && (m_tdata[106:105] != 2'd3) && (m_tdata[111:107] == 5'd0), "bad kind or fault code")
    `MSTU_ASSERT(a_chunk, clk, rst_n, m_tvalid && (m_tuser == 4'd5), (m_tdata[96:64] == 33'd1) && (m_tdata[63:8] == 56'd0) && (m_tdata[106:97] == 10'd0), "malformed chunk")

endmodule

bind msgpack_stream_tokenizer_unit mstu_checker u_mstu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
